// File: src/climrc_pkg.sv
`default_nettype none
package climrc_pkg;

   // Control tick period and door timeout.
   localparam int TICK_MS        = 5000;
   localparam int DOOR_TIMEOUT_S = 900;

   localparam int DOOR_STEP_INT  = (TICK_MS / 1000 == 0) ? 1 : TICK_MS / 1000;
   localparam logic [9:0] DOOR_STEP    = 10'(DOOR_STEP_INT);
   localparam logic [9:0] DOOR_TIMEOUT = 10'(DOOR_TIMEOUT_S);
   localparam logic [39:0] TICK_MS_40  = 40'(TICK_MS);

   localparam logic [15:0] MS_PER_MIN = 16'd60000;
   localparam int PERIOD_W = 27;
   localparam int IDLE_W   = 26;

   // Status and relay bit positions.
   localparam int BIT_HEAT  = 0;
   localparam int BIT_COOL  = 1;
   localparam int BIT_HUM   = 2;
   localparam int BIT_LIGHT = 3;
   localparam int BIT_VENT  = 4;

   // Inhibit mask bit positions.
   localparam int INH_TEMP  = 0;
   localparam int INH_HUM   = 1;
   localparam int INH_LIGHT = 2;
   localparam int INH_VENT  = 3;

   localparam logic [4:0] RELAY_LAMP_ONLY = 5'(1 << BIT_LIGHT);

   // Reset values of the registers.
   localparam logic [9:0]  RST_TEMP_SP    = 10'd235;
   localparam logic [9:0]  RST_TEMP_BAND  = 10'd10;
   localparam logic [9:0]  RST_HUM_SP     = 10'd950;
   localparam logic [9:0]  RST_HUM_BAND   = 10'd10;
   localparam logic [11:0] RST_LAMP_START = 12'd600;
   localparam logic [11:0] RST_LAMP_STOP  = 12'd1800;
   localparam logic [9:0]  RST_FAN_RUN    = 10'd15;
   localparam logic [9:0]  RST_FAN_IDLE   = 10'd105;
   localparam logic [PERIOD_W-1:0] RST_PERIOD_MS = PERIOD_W'((15 + 105) * 60000);
   localparam logic [IDLE_W-1:0]   RST_IDLE_MS   = IDLE_W'(105 * 60000);

   typedef enum logic [1:0] {
      REQ_TICK        = 2'd0,
      REQ_DOOR_ENTER  = 2'd1,
      REQ_DOOR_EXIT   = 2'd2,
      REQ_FAN_RESTART = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_TEMP_SP    = 3'd0,
      CSR_TEMP_BAND  = 3'd1,
      CSR_HUM_SP     = 3'd2,
      CSR_HUM_BAND   = 3'd3,
      CSR_LAMP_START = 3'd4,
      CSR_LAMP_STOP  = 3'd5,
      CSR_FAN_RUN    = 3'd6,
      CSR_FAN_IDLE   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [9:0]          temp_sp;
      logic [9:0]          temp_band;
      logic [9:0]          hum_sp;
      logic [9:0]          hum_band;
      logic [11:0]         lamp_start;
      logic [11:0]         lamp_stop;
      logic [PERIOD_W-1:0] period_ms;
      logic [IDLE_W-1:0]   idle_ms;
   } climrc_cfg_type;

   typedef struct packed {
      logic [4:0]  status;
      logic [4:0]  relay;
      logic [39:0] fan_start;
      logic [39:0] fan_stop;
      logic        door_flag;
      logic [9:0]  door_secs;
   } climrc_state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [31:0]        now_ms;
      logic signed [11:0] temp_reading;
      logic [9:0]         humidity_reading;
      logic [4:0]         clock_hour;
      logic [5:0]         clock_minute;
      logic [3:0]         inhibit_mask;
   } climrc_item_type;

endpackage
`default_nettype wire

// File: src/climate_relay_controller_core.sv
`default_nettype none
// Climate relay controller core.
// An accepted item's result is registered in main_data_ff, or in skid_data_ff if full.
// Throughput: one item per cycle while req_tready is high; one pass of logic per item.
// A two-entry output buffer keeps req_tready high while one result waits downstream.
// Reset (synchronous, active high) restores register defaults and clears state_ff.
module climate_relay_controller_core
   import climrc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], temp_reading[43:32], humidity_reading[53:44], clock_hour[58:54],
   // clock_minute[64:59], inhibit_mask[68:65], zero fill [71:69]
   input  wire  [71:0] req_tdata,
   // req_type[1:0]
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // status_bits[4:0], relay_drive[9:5], door_active[10], zero fill [15:11]
   output logic [15:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [11:0] csr_wdata
);

   climrc_cfg_type   cfg_ff, cfg_in;
   logic [9:0]       fan_run_ff, fan_run_in;
   logic [9:0]       fan_idle_ff, fan_idle_in;
   climrc_state_type state_ff, state_in;
   climrc_state_type state_nxt;
   climrc_item_type  item;
   logic             accept;
   logic             take;
   logic [15:0]      result;
   logic             main_valid_ff, main_valid_in;
   logic [15:0]      main_data_ff, main_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [15:0]      skid_data_ff, skid_data_in;

   assign item.req_type         = req_tuser;
   assign item.now_ms           = req_tdata[31:0];
   assign item.temp_reading     = $signed(req_tdata[43:32]);
   assign item.humidity_reading = req_tdata[53:44];
   assign item.clock_hour       = req_tdata[58:54];
   assign item.clock_minute     = req_tdata[64:59];
   assign item.inhibit_mask     = req_tdata[68:65];

   // Fan periods in ms are formed at write time so no multiply sits in the item path.
   always_comb begin
      cfg_in      = cfg_ff;
      fan_run_in  = fan_run_ff;
      fan_idle_in = fan_idle_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_SP:    cfg_in.temp_sp    = csr_wdata[9:0];
            CSR_TEMP_BAND:  cfg_in.temp_band  = csr_wdata[9:0];
            CSR_HUM_SP:     cfg_in.hum_sp     = csr_wdata[9:0];
            CSR_HUM_BAND:   cfg_in.hum_band   = csr_wdata[9:0];
            CSR_LAMP_START: cfg_in.lamp_start = csr_wdata;
            CSR_LAMP_STOP:  cfg_in.lamp_stop  = csr_wdata;
            CSR_FAN_RUN: begin
               fan_run_in       = csr_wdata[9:0];
               cfg_in.period_ms = PERIOD_W'(({1'b0, csr_wdata[9:0]} + {1'b0, fan_idle_ff})
                                            * MS_PER_MIN);
            end
            CSR_FAN_IDLE: begin
               fan_idle_in      = csr_wdata[9:0];
               cfg_in.period_ms = PERIOD_W'(({1'b0, fan_run_ff} + {1'b0, csr_wdata[9:0]})
                                            * MS_PER_MIN);
               cfg_in.idle_ms   = IDLE_W'(csr_wdata[9:0] * MS_PER_MIN);
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   climrc_ctrl u_ctrl (
      .item (item),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_nxt)
   );

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = main_valid_ff && rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;
   assign state_in   = accept ? state_nxt : state_ff;
   assign result     = {5'd0, state_nxt.door_flag, state_nxt.relay, state_nxt.status};

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_sp    <= RST_TEMP_SP;
         cfg_ff.temp_band  <= RST_TEMP_BAND;
         cfg_ff.hum_sp     <= RST_HUM_SP;
         cfg_ff.hum_band   <= RST_HUM_BAND;
         cfg_ff.lamp_start <= RST_LAMP_START;
         cfg_ff.lamp_stop  <= RST_LAMP_STOP;
         cfg_ff.period_ms  <= RST_PERIOD_MS;
         cfg_ff.idle_ms    <= RST_IDLE_MS;
         fan_run_ff        <= RST_FAN_RUN;
         fan_idle_ff       <= RST_FAN_IDLE;
         state_ff          <= '0;
         main_valid_ff     <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         fan_run_ff    <= fan_run_in;
         fan_idle_ff   <= fan_idle_in;
         state_ff      <= state_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
`default_nettype wire

// File: src/climrc_ctrl.sv
`default_nettype none
module climrc_ctrl
   import climrc_pkg::*;
(
   input  wire climrc_item_type  item,
   input  wire climrc_cfg_type   cfg,
   input  wire climrc_state_type cur,
   output climrc_state_type      nxt
);

   logic [39:0] now40;
   logic [39:0] roll_stop;
   logic [39:0] roll_start;
   logic [39:0] restart_stop;
   logic [39:0] restart_start;
   logic        rollover;
   logic [39:0] start_mid;
   logic        vent_sched;
   logic [10:0] hum_hi;
   logic [10:0] hum_lo_sum;
   logic        hum_off;
   logic        hum_on;
   logic        hum_bit;
   logic        vent_extend;
   logic [11:0] ltime;
   logic        light_win;
   logic        light;
   logic [10:0] temp_hi;
   logic signed [13:0] temp_lo_sum;
   logic        cool;
   logic        heat;
   logic [4:0]  tick_status;
   logic [39:0] tick_start;
   logic [39:0] tick_stop;

   assign now40 = {8'd0, item.now_ms};

   // Both deadlines move by whole periods, so the new start is the old stop plus idle.
   assign roll_stop     = cur.fan_stop + 40'(cfg.period_ms);
   assign roll_start    = cur.fan_stop + 40'(cfg.idle_ms);
   assign restart_stop  = now40 + 40'(cfg.period_ms);
   assign restart_start = now40 + 40'(cfg.idle_ms);

   assign rollover   = now40 > cur.fan_stop;
   assign start_mid  = rollover ? roll_start : cur.fan_start;
   assign tick_stop  = rollover ? roll_stop : cur.fan_stop;
   assign vent_sched = !rollover && (now40 > cur.fan_start) && !item.inhibit_mask[INH_VENT];

   assign hum_hi     = {1'b0, cfg.hum_sp} + {1'b0, cfg.hum_band};
   assign hum_lo_sum = {1'b0, item.humidity_reading} + {1'b0, cfg.hum_band};
   assign hum_off    = ({1'b0, item.humidity_reading} > hum_hi) || item.inhibit_mask[INH_HUM];
   assign hum_on     = hum_lo_sum < {1'b0, cfg.hum_sp};
   assign hum_bit    = hum_off ? 1'b0 : (hum_on ? 1'b1 : cur.status[BIT_HUM]);

   // A humidifying tick before the run phase vents at once and delays the run by a tick.
   assign vent_extend = hum_bit && (now40 < start_mid);
   assign tick_start  = vent_extend ? start_mid + TICK_MS_40 : start_mid;

   assign ltime = 12'(item.clock_hour * 7'd100) + {6'd0, item.clock_minute};
   always_comb begin
      if (cfg.lamp_start < cfg.lamp_stop) begin
         light_win = (ltime >= cfg.lamp_start) && (ltime < cfg.lamp_stop);
      end else if (cfg.lamp_start > cfg.lamp_stop) begin
         light_win = (ltime >= cfg.lamp_start) || (ltime < cfg.lamp_stop);
      end else begin
         light_win = 1'b0;
      end
   end
   assign light = light_win && !item.inhibit_mask[INH_LIGHT];

   assign temp_hi     = {1'b0, cfg.temp_sp} + {1'b0, cfg.temp_band};
   assign temp_lo_sum = 14'(item.temp_reading) + $signed({4'd0, cfg.temp_band});
   assign cool = !item.inhibit_mask[INH_TEMP]
                 && ($signed({item.temp_reading[11], item.temp_reading}) >
                     $signed({2'd0, temp_hi}));
   assign heat = !item.inhibit_mask[INH_TEMP] && !cool
                 && (temp_lo_sum < $signed({4'd0, cfg.temp_sp}));

   always_comb begin
      tick_status            = 5'd0;
      tick_status[BIT_HEAT]  = heat;
      tick_status[BIT_COOL]  = cool;
      tick_status[BIT_HUM]   = hum_bit;
      tick_status[BIT_LIGHT] = light;
      tick_status[BIT_VENT]  = vent_sched || vent_extend;
   end

   always_comb begin
      nxt = cur;
      unique case (req_kind_type'(item.req_type))
         REQ_TICK: begin
            if (cur.door_flag) begin
               if (cur.door_secs <= DOOR_STEP) begin
                  nxt.door_secs = 10'd0;
                  nxt.door_flag = 1'b0;
               end else begin
                  nxt.door_secs = cur.door_secs - DOOR_STEP;
               end
               nxt.relay = RELAY_LAMP_ONLY;
            end else begin
               nxt.status    = tick_status;
               nxt.relay     = tick_status;
               nxt.fan_start = tick_start;
               nxt.fan_stop  = tick_stop;
            end
         end
         REQ_DOOR_ENTER: begin
            nxt.door_flag = 1'b1;
            nxt.door_secs = DOOR_TIMEOUT;
         end
         REQ_DOOR_EXIT: begin
            nxt.door_flag = 1'b0;
            nxt.door_secs = 10'd0;
         end
         REQ_FAN_RESTART: begin
            nxt.fan_start = restart_start;
            nxt.fan_stop  = restart_stop;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule
`default_nettype wire
